[rtl/lpr_pkg.sv]
// ----------------------------------------------------------------------------
// lpr_pkg: shared definitions for the length-prefixed packet ring.
// Field widths, default sizes, operation and status codes, and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lpr_pkg;

   // Default sizes for the top-level parameters.
   localparam int RING_BYTES_DEF   = 4096;
   localparam int RESERVE_BYTES_DEF = 8;
   localparam int HEADER_BYTES_DEF = 4;

   // Widths of the transaction fields.
   localparam int OPCODE_W   = 2;
   localparam int LEN_W      = 13;
   localparam int DATA_W     = 8;
   localparam int STATUS_W   = 3;
   localparam int FREE_OUT_W = 13;
   localparam int FREE_SAT   = (1 << FREE_OUT_W) - 1;

   // Request operations.
   typedef enum logic [OPCODE_W-1:0] {
      OP_START = 2'd0,
      OP_PUT   = 2'd1,
      OP_GET   = 2'd2
   } op_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_FULL    = 3'd2,
      ST_CORRUPT = 3'd3,
      ST_SEQ     = 3'd4
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;          // capture the accepted request
      logic       hdr_wr_start;  // open a put: cursor to write pointer
      logic       hdr_wr_step;   // write one header byte
      logic       put_byte;      // store one data byte
      logic       hdr_rd_start;  // begin reading a header
      logic       hdr_rd_step;   // collect one header byte
      logic       get_byte;      // return one data byte
      logic       clear;         // drop all pointers after a corrupt header
      logic       finish;        // the response is ready this cycle
      status_type code;          // status of that response
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                wr_open;
      logic                rd_open;
      logic                empty;
      logic                short_ring;
      logic                len_bad;
      logic                hdr_last;
      logic                hdr_bad;
      logic                slot_free;
   } dp_stat_type;

endpackage

[rtl/lpr_if.sv]
// ----------------------------------------------------------------------------
// lpr_if: request and response channels of the packet ring.
// Each channel carries valid, ready and the transaction fields.
// ----------------------------------------------------------------------------
interface lpr_req_if;
   logic                          valid;
   logic                          ready;
   logic [lpr_pkg::OPCODE_W-1:0]  opcode;
   logic [lpr_pkg::LEN_W-1:0]     packet_length;
   logic [lpr_pkg::DATA_W-1:0]    data_in;

   modport source (output valid, output opcode, output packet_length,
                   output data_in, input ready);
   modport sink   (input valid, input opcode, input packet_length,
                   input data_in, output ready);
endinterface

interface lpr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lpr_pkg::STATUS_W-1:0]    status;
   logic [lpr_pkg::DATA_W-1:0]      data_out;
   logic                            last;
   logic [lpr_pkg::FREE_OUT_W-1:0]  free_bytes;

   modport source (output valid, output status, output data_out,
                   output last, output free_bytes, input ready);
   modport sink   (input valid, input status, input data_out,
                   input last, input free_bytes, output ready);
endinterface

[rtl/lpr_ram.sv]
// ----------------------------------------------------------------------------
// lpr_ram: generic single-clock RAM.
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lpr_dp.sv]
// ----------------------------------------------------------------------------
// lpr_dp: datapath of the packet ring.
// Holds the pointers, cursors and byte counts, the ring memory, the header
// assembly register and a two-entry response buffer.
// ----------------------------------------------------------------------------
module lpr_dp #(
   parameter int RING_BYTES    = lpr_pkg::RING_BYTES_DEF,
   parameter int RESERVE_BYTES = lpr_pkg::RESERVE_BYTES_DEF,
   parameter int HEADER_BYTES  = lpr_pkg::HEADER_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [lpr_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [lpr_pkg::LEN_W-1:0]      req_packet_length,
   input  logic [lpr_pkg::DATA_W-1:0]     req_data_in,
   input  lpr_pkg::cmd_type               cmd,
   output lpr_pkg::dp_stat_type           stat,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [lpr_pkg::STATUS_W-1:0]   rsp_status,
   output logic [lpr_pkg::DATA_W-1:0]     rsp_data_out,
   output logic                           rsp_last,
   output logic [lpr_pkg::FREE_OUT_W-1:0] rsp_free_bytes
);

   localparam int PTR_W  = $clog2(RING_BYTES);
   localparam int KEEP   = (RESERVE_BYTES > 0) ? RESERVE_BYTES : 1;
   localparam int CNT_W  = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
   localparam int HDR_W  = 8 * HEADER_BYTES;
   localparam int CALC_W = 33;
   localparam int FOUT_W = lpr_pkg::FREE_OUT_W;
   localparam int DW     = lpr_pkg::DATA_W;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [CALC_W-1:0] calc_type;

   localparam calc_type RING_C    = CALC_W'(RING_BYTES);
   localparam calc_type KEEP_C    = CALC_W'(KEEP);
   localparam calc_type HDR_C     = CALC_W'(HEADER_BYTES);
   localparam calc_type LEN_LIMIT = calc_type'(1) << HDR_W;
   localparam calc_type SAT_C     = CALC_W'(lpr_pkg::FREE_SAT);
   localparam ptr_type  PTR_LAST  = PTR_W'(RING_BYTES - 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HEADER_BYTES - 1);

   typedef struct packed {
      lpr_pkg::status_type   status;
      logic [DW-1:0]         data_out;
      logic                  last;
      logic [FOUT_W-1:0]     free_bytes;
   } result_type;

   // Advance a ring address by one, wrapping at the ring size.
   function automatic ptr_type ptr_inc(input ptr_type p);
      ptr_inc = (p == PTR_LAST) ? '0 : ptr_type'(p + 1'b1);
   endfunction

   // Bytes between the read and write pointers.
   function automatic calc_type used_of(input ptr_type w, input ptr_type r);
      calc_type wc;
      calc_type rc;
      wc = CALC_W'(w);
      rc = CALC_W'(r);
      used_of = (w >= r) ? (wc - rc) : (wc + RING_C - rc);
   endfunction

   // Writable bytes once the reserve is kept back.
   function automatic calc_type free_of(input calc_type used);
      calc_type taken;
      taken = used + KEEP_C;
      free_of = (taken >= RING_C) ? '0 : (RING_C - taken);
   endfunction

   // Captured request.
   logic [lpr_pkg::OPCODE_W-1:0] op_ff, op_in;
   logic [lpr_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [DW-1:0]                din_ff, din_in;

   // Pointers, cursors and counts.
   ptr_type wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   ptr_type wr_cur_ff, wr_cur_in, rd_cur_ff, rd_cur_in;
   ptr_type wr_rem_ff, wr_rem_in, rd_rem_ff, rd_rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [HDR_W-1:0] hdr_ff, hdr_in, hdr_val;

   // Response buffer.
   result_type out_ff, out_in, pend_ff, pend_in, res;
   logic       out_valid_ff, out_valid_in, pend_valid_ff, pend_valid_in;
   logic       out_free;

   // Memory port signals.
   logic          ram_we;
   ptr_type       ram_waddr;
   logic [DW-1:0] ram_wdata;
   logic [DW-1:0] ram_q;

   calc_type used_cur, free_cur, len_ext, free_next;
   logic [31:0] len_wide;
   logic [DW-1:0] hdr_byte;
   logic hdr_bad;

   lpr_ram #(
      .WIDTH (DW),
      .DEPTH (RING_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_cur_in),
      .rd_data (ram_q)
   );

   // Occupancy and the checks the controller branches on.
   always_comb begin
      used_cur = used_of(wr_ptr_ff, rd_ptr_ff);
      free_cur = free_of(used_cur);
      len_ext  = CALC_W'(len_ff);
      len_wide = 32'(len_ff);
      hdr_byte = len_wide[{cnt_ff, 3'b000} +: 8];
   end

   // Header value with the byte arriving this cycle merged into its lane.
   always_comb begin
      for (int l = 0; l < HEADER_BYTES; l++) begin
         hdr_val[8*l +: 8] = (cnt_ff == CNT_W'(l)) ? ram_q : hdr_ff[8*l +: 8];
      end
   end

   assign hdr_bad = (hdr_val == '0) || (CALC_W'(hdr_val) > (used_cur - HDR_C));

   always_comb begin
      stat.op         = op_ff;
      stat.wr_open    = (wr_rem_ff != '0);
      stat.rd_open    = (rd_rem_ff != '0);
      stat.empty      = (wr_ptr_ff == rd_ptr_ff);
      stat.short_ring = (used_cur < HDR_C);
      stat.len_bad    = (len_ff == '0) || (len_ext >= LEN_LIMIT) ||
                        ((len_ext + HDR_C) > free_cur);
      stat.hdr_last   = (cnt_ff == CNT_LAST);
      stat.hdr_bad    = hdr_bad;
      stat.slot_free  = !pend_valid_ff;
   end

   // Next values of the ring state, driven by the controller's commands.
   always_comb begin
      op_in     = op_ff;
      len_in    = len_ff;
      din_in    = din_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_cur_in = wr_cur_ff;
      rd_cur_in = rd_cur_ff;
      wr_rem_in = wr_rem_ff;
      rd_rem_in = rd_rem_ff;
      cnt_in    = cnt_ff;
      hdr_in    = hdr_ff;
      ram_we    = 1'b0;
      ram_waddr = wr_cur_ff;
      ram_wdata = din_ff;
      res.data_out = '0;
      res.last     = 1'b0;

      if (cmd.load) begin
         op_in  = req_opcode;
         len_in = req_packet_length;
         din_in = req_data_in;
      end

      // Header write: one length byte per cycle, low byte first.
      if (cmd.hdr_wr_start) begin
         wr_cur_in = wr_ptr_ff;
         cnt_in    = '0;
      end
      if (cmd.hdr_wr_step) begin
         ram_we    = 1'b1;
         ram_wdata = hdr_byte;
         wr_cur_in = ptr_inc(wr_cur_ff);
         cnt_in    = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_LAST) begin
            wr_rem_in = PTR_W'(len_ff);
         end
      end

      // Data byte of an open put; publish the packet on its last byte.
      if (cmd.put_byte) begin
         ram_we    = 1'b1;
         wr_cur_in = ptr_inc(wr_cur_ff);
         wr_rem_in = ptr_type'(wr_rem_ff - 1'b1);
         if (wr_rem_ff == ptr_type'(1)) begin
            wr_ptr_in = ptr_inc(wr_cur_ff);
         end
      end

      // Header read: one byte per cycle from the read cursor.
      if (cmd.hdr_rd_start) begin
         cnt_in = '0;
      end
      if (cmd.hdr_rd_step) begin
         hdr_in    = hdr_val;
         rd_cur_in = ptr_inc(rd_cur_ff);
         cnt_in    = CNT_W'(cnt_ff + 1'b1);
         if ((cnt_ff == CNT_LAST) && !hdr_bad) begin
            rd_rem_in = PTR_W'(hdr_val);
         end
      end

      // Data byte of an open get; release the packet on its last byte.
      if (cmd.get_byte) begin
         res.data_out = ram_q;
         rd_cur_in    = ptr_inc(rd_cur_ff);
         rd_rem_in    = ptr_type'(rd_rem_ff - 1'b1);
         if (rd_rem_ff == ptr_type'(1)) begin
            res.last  = 1'b1;
            rd_ptr_in = ptr_inc(rd_cur_ff);
         end
      end

      // Corrupt header: everything back to an empty ring.
      if (cmd.clear) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         wr_cur_in = '0;
         rd_cur_in = '0;
         wr_rem_in = '0;
         rd_rem_in = '0;
      end

      // Response fields; free space is taken from the pointers after this transaction.
      free_next      = free_of(used_of(wr_ptr_in, rd_ptr_in));
      res.status     = cmd.code;
      res.free_bytes = (free_next > SAT_C) ? FOUT_W'(lpr_pkg::FREE_SAT)
                                           : FOUT_W'(free_next);
   end

   // Two-entry response buffer: a finished response goes straight to the
   // output register if it is free, otherwise it waits in the pending slot.
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_in        = out_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      pend_valid_in = pend_valid_ff;
      if (cmd.finish) begin
         if (out_free) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            pend_in       = res;
            pend_valid_in = 1'b1;
         end
      end else if (pend_valid_ff && out_free) begin
         out_in        = pend_ff;
         out_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end else if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         wr_cur_ff     <= '0;
         rd_cur_ff     <= '0;
         wr_rem_ff     <= '0;
         rd_rem_ff     <= '0;
         cnt_ff        <= '0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_cur_ff     <= wr_cur_in;
         rd_cur_ff     <= rd_cur_in;
         wr_rem_ff     <= wr_rem_in;
         rd_rem_ff     <= rd_rem_in;
         cnt_ff        <= cnt_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      len_ff  <= len_in;
      din_ff  <= din_in;
      hdr_ff  <= hdr_in;
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_ff.status;
   assign rsp_data_out   = out_ff.data_out;
   assign rsp_last       = out_ff.last;
   assign rsp_free_bytes = out_ff.free_bytes;

endmodule

[rtl/lpr_ctrl.sv]
// ----------------------------------------------------------------------------
// lpr_ctrl: controller of the packet ring.
// Takes one request transaction at a time and steps the datapath through
// header writes, header reads and single-byte moves.
// ----------------------------------------------------------------------------
module lpr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lpr_pkg::dp_stat_type stat,
   output lpr_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_HDR_WR,
      S_HDR_RD,
      S_RD_DATA
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.code  = lpr_pkg::ST_OK;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = stat.slot_free;
            if (req_valid && stat.slot_free) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end

         // Decode the captured request.
         S_EXEC: begin
            state_in = S_IDLE;
            priority if (stat.op == lpr_pkg::OP_START) begin
               priority if (stat.wr_open) begin
                  cmd.finish = 1'b1;
                  cmd.code   = lpr_pkg::ST_SEQ;
               end else if (stat.len_bad) begin
                  cmd.finish = 1'b1;
                  cmd.code   = lpr_pkg::ST_FULL;
               end else begin
                  cmd.hdr_wr_start = 1'b1;
                  state_in         = S_HDR_WR;
               end
            end else if (stat.op == lpr_pkg::OP_PUT) begin
               cmd.finish = 1'b1;
               if (stat.wr_open) begin
                  cmd.put_byte = 1'b1;
               end else begin
                  cmd.code = lpr_pkg::ST_SEQ;
               end
            end else if (stat.op == lpr_pkg::OP_GET) begin
               priority if (stat.rd_open) begin
                  cmd.get_byte = 1'b1;
                  cmd.finish   = 1'b1;
               end else if (stat.empty) begin
                  cmd.finish = 1'b1;
                  cmd.code   = lpr_pkg::ST_EMPTY;
               end else if (stat.short_ring) begin
                  cmd.clear  = 1'b1;
                  cmd.finish = 1'b1;
                  cmd.code   = lpr_pkg::ST_CORRUPT;
               end else begin
                  cmd.hdr_rd_start = 1'b1;
                  state_in         = S_HDR_RD;
               end
            end else begin
               cmd.finish = 1'b1;
               cmd.code   = lpr_pkg::ST_SEQ;
            end
         end

         // Write the length header, one byte per cycle.
         S_HDR_WR: begin
            cmd.hdr_wr_step = 1'b1;
            if (stat.hdr_last) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end

         // Read the length header and check it against the stored bytes.
         S_HDR_RD: begin
            cmd.hdr_rd_step = 1'b1;
            if (stat.hdr_last) begin
               if (stat.hdr_bad) begin
                  cmd.clear  = 1'b1;
                  cmd.finish = 1'b1;
                  cmd.code   = lpr_pkg::ST_CORRUPT;
                  state_in   = S_IDLE;
               end else begin
                  state_in = S_RD_DATA;
               end
            end
         end

         // First data byte of a packet after its header.
         S_RD_DATA: begin
            cmd.get_byte = 1'b1;
            cmd.finish   = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/length_prefixed_packet_ring.sv]
// ----------------------------------------------------------------------------
// length_prefixed_packet_ring: byte ring of length-prefixed packets.
// A put-data or in-packet get is captured, decoded, and its response registered.
// A put start and a packet's first get also walk the header, one byte per cycle,
// through the byte-wide ring memory. One transaction is in work at a time; the next
// is taken once the controller is idle and the pending response slot is free.
// Reset clears pointers and counts at once; ring contents stay undefined until written.
// ----------------------------------------------------------------------------
module length_prefixed_packet_ring #(
   parameter int RING_BYTES    = lpr_pkg::RING_BYTES_DEF,
   parameter int RESERVE_BYTES = lpr_pkg::RESERVE_BYTES_DEF,
   parameter int HEADER_BYTES  = lpr_pkg::HEADER_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lpr_req_if.sink   req_ch,
   lpr_rsp_if.source rsp_ch
);

   lpr_pkg::cmd_type     cmd;
   lpr_pkg::dp_stat_type stat;

   // Controller.
   lpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath with the ring memory and response buffer.
   lpr_dp #(
      .RING_BYTES    (RING_BYTES),
      .RESERVE_BYTES (RESERVE_BYTES),
      .HEADER_BYTES  (HEADER_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_opcode        (req_ch.opcode),
      .req_packet_length (req_ch.packet_length),
      .req_data_in       (req_ch.data_in),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_status        (rsp_ch.status),
      .rsp_data_out      (rsp_ch.data_out),
      .rsp_last          (rsp_ch.last),
      .rsp_free_bytes    (rsp_ch.free_bytes)
   );

   // Only one transaction is in work: ready drops after each acceptance.
   assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted while another is in work");

   // A finished response always finds room in the response buffer.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> stat.slot_free)
      else $error("response finished with the pending slot full");

   // A corrupt-header reset leaves an empty ring with no put open.
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> stat.empty && !stat.wr_open && !stat.rd_open)
      else $error("ring not empty after a corrupt-header reset");

   // The final byte of a packet is only ever returned with an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.last |-> rsp_ch.status == lpr_pkg::ST_OK)
      else $error("last flag set on a failed transaction");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the length-prefixed packet ring.
// A small scoreboard class keeps its own copy of the ring, the pointers and
// the open put and get, and predicts the response of every accepted
// transaction. Directed cases cover the rejects, the sequence errors and the
// empty ring. Random packet traffic with stray transactions follows, with
// random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_SIZE  = lpr_pkg::RING_BYTES_DEF;
   localparam int RESERVE    = lpr_pkg::RESERVE_BYTES_DEF;
   localparam int HEADER_LEN = lpr_pkg::HEADER_BYTES_DEF;

   // The opcode field has one code that the block does not define.
   localparam logic [lpr_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

   // Largest packet that fits into an empty ring together with its header.
   localparam int MAX_PACKET = RING_SIZE - RESERVE - HEADER_LEN;

   localparam int RANDOM_ITEMS = 1250;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      lpr_pkg::status_type                status;
      logic [lpr_pkg::DATA_W-1:0]         data;
      logic                               last;
      logic [lpr_pkg::FREE_OUT_W-1:0]     free;
   } ring_reply_type;

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of the ring state and the queue of replies due.
   // -------------------------------------------------------------------------
   class ring_scoreboard;
      bit [7:0]       ring_mem [RING_SIZE];
      int unsigned    wr_ptr, rd_ptr, wr_cursor, wr_left, rd_cursor, rd_left;
      ring_reply_type replies_due [$];
      int unsigned    failures;
      int unsigned    replies_checked;
      int unsigned    op_seen [4];
      int unsigned    status_seen [8];
      int unsigned    biggest_packet;

      function void clear_pointers();
         wr_ptr = 0;
         rd_ptr = 0;
         wr_cursor = 0;
         wr_left = 0;
         rd_cursor = 0;
         rd_left = 0;
      endfunction

      function int unsigned used_bytes();
         return (wr_ptr + RING_SIZE - rd_ptr) % RING_SIZE;
      endfunction

      // Room left for new packets, judged from the published pointers only.
      function int unsigned free_room();
         int unsigned keep;
         int unsigned taken;
         keep = (RESERVE > 0) ? RESERVE : 1;
         taken = used_bytes() + keep;
         if (taken >= RING_SIZE) return 0;
         if (RING_SIZE - taken > lpr_pkg::FREE_SAT) return lpr_pkg::FREE_SAT;
         return RING_SIZE - taken;
      endfunction

      function bit put_open();
         return wr_left != 0;
      endfunction

      function int unsigned pending();
         return replies_due.size();
      endfunction

      function void fail(string msg);
         failures++;
         if (failures <= REPORT_LIMIT) $display("ERROR: %s", msg);
      endfunction

      // Works out the reply to one accepted request and queues it.
      function void log_request(logic [lpr_pkg::OPCODE_W-1:0] opcode,
                                logic [lpr_pkg::LEN_W-1:0] length,
                                logic [lpr_pkg::DATA_W-1:0] din);
         ring_reply_type   rep;
         int unsigned      p;
         int unsigned      used;
         longint unsigned  hdr;
         bit               ok;
         rep.status = lpr_pkg::ST_OK;
         rep.data = '0;
         rep.last = 1'b0;
         op_seen[opcode]++;
         case (opcode)
            lpr_pkg::OP_START: begin
               if (wr_left != 0) begin
                  rep.status = lpr_pkg::ST_SEQ;
               end else if (length == 0 || (64'(length) >> (8 * HEADER_LEN)) != 0 ||
                            64'(length) + HEADER_LEN > free_room()) begin
                  rep.status = lpr_pkg::ST_FULL;
               end else begin
                  // Header goes in low byte first, ahead of the data.
                  p = wr_ptr;
                  for (int i = 0; i < HEADER_LEN; i++) begin
                     ring_mem[p] = 8'(32'(length) >> (8 * i));
                     p = (p + 1) % RING_SIZE;
                  end
                  wr_cursor = p;
                  wr_left = 32'(length);
                  if (length > biggest_packet) biggest_packet = 32'(length);
               end
            end
            lpr_pkg::OP_PUT: begin
               if (wr_left == 0) begin
                  rep.status = lpr_pkg::ST_SEQ;
               end else begin
                  ring_mem[wr_cursor] = din;
                  wr_cursor = (wr_cursor + 1) % RING_SIZE;
                  wr_left--;
                  if (wr_left == 0) wr_ptr = wr_cursor;
               end
            end
            lpr_pkg::OP_GET: begin
               ok = 1'b1;
               if (rd_left == 0) begin
                  if (rd_ptr == wr_ptr) begin
                     rep.status = lpr_pkg::ST_EMPTY;
                     ok = 1'b0;
                  end else begin
                     // First get of a packet: fetch and sanity-check the header.
                     used = used_bytes();
                     hdr = 0;
                     p = rd_ptr;
                     if (used < HEADER_LEN) begin
                        ok = 1'b0;
                     end else begin
                        for (int i = 0; i < HEADER_LEN; i++) begin
                           hdr |= 64'(ring_mem[p]) << (8 * i);
                           p = (p + 1) % RING_SIZE;
                        end
                        if (hdr == 0 || hdr > used - HEADER_LEN) ok = 1'b0;
                     end
                     if (!ok) begin
                        clear_pointers();
                        rep.status = lpr_pkg::ST_CORRUPT;
                     end else begin
                        rd_cursor = p;
                        rd_left = 32'(hdr);
                     end
                  end
               end
               if (ok) begin
                  rep.data = ring_mem[rd_cursor];
                  rd_cursor = (rd_cursor + 1) % RING_SIZE;
                  rd_left--;
                  if (rd_left == 0) begin
                     rep.last = 1'b1;
                     rd_ptr = rd_cursor;
                  end
               end
            end
            default: rep.status = lpr_pkg::ST_SEQ;
         endcase
         rep.free = lpr_pkg::FREE_OUT_W'(free_room());
         status_seen[rep.status]++;
         replies_due.push_back(rep);
      endfunction

      // Compares one accepted response with the oldest reply due.
      function void check_reply(logic [lpr_pkg::STATUS_W-1:0] status,
                                logic [lpr_pkg::DATA_W-1:0] data,
                                logic last,
                                logic [lpr_pkg::FREE_OUT_W-1:0] free);
         ring_reply_type want;
         string          exp_s;
         string          got_s;
         if (replies_due.size() == 0) begin
            fail($sformatf("response status=%0d data=%0d with no request outstanding",
                           status, data));
            return;
         end
         want = replies_due.pop_front();
         replies_checked++;
         if (status !== want.status || data !== want.data || last !== want.last ||
             free !== want.free) begin
            exp_s = $sformatf("response %0d: expected status=%0d data=%0d last=%0d free=%0d",
                              replies_checked, want.status, want.data, want.last,
                              want.free);
            got_s = $sformatf(", got status=%0d data=%0d last=%0d free=%0d",
                              status, data, last, free);
            fail({exp_s, got_s});
         end
      endfunction

      function void report_leftover();
         if (replies_due.size() != 0)
            fail($sformatf("%0d responses never arrived", replies_due.size()));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, channels and the block itself.
   // -------------------------------------------------------------------------
   logic clock;
   logic reset;

   lpr_req_if req_bus ();
   lpr_rsp_if rsp_bus ();

   length_prefixed_packet_ring #(
      .RING_BYTES    (RING_SIZE),
      .RESERVE_BYTES (RESERVE),
      .HEADER_BYTES  (HEADER_LEN)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   ring_scoreboard tracker = new();

   int unsigned hold_left;    // long receiver hold-off, in cycles
   int unsigned calm_items;   // requests still to send back to back
   int unsigned items_sent;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit, far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Idle length: mostly none, often short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // -------------------------------------------------------------------------
   // Response side: check at the rising edge, decide ready at the falling edge.
   // -------------------------------------------------------------------------
   initial begin
      int unsigned stall_left;
      int unsigned calm_left;
      int unsigned r;
      stall_left = 0;
      calm_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            tracker.check_reply(rsp_bus.status, rsp_bus.data_out, rsp_bus.last,
                                rsp_bus.free_bytes);
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_bus.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 2) calm_left = $urandom_range(60, 240);
            else if (r < 27) stall_left = pick_gap();
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request side. Each task is entered and left at a falling edge.
   // -------------------------------------------------------------------------
   task automatic send_request(logic [lpr_pkg::OPCODE_W-1:0] opcode,
                               logic [lpr_pkg::LEN_W-1:0] length,
                               logic [lpr_pkg::DATA_W-1:0] din);
      int unsigned gap;
      req_bus.valid <= 1'b1;
      req_bus.opcode <= opcode;
      req_bus.packet_length <= length;
      req_bus.data_in <= din;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      tracker.log_request(opcode, length, din);
      items_sent++;
      @(negedge clock);
      if (calm_items > 0) begin
         calm_items--;
         gap = 0;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 99) < 2) calm_items = $urandom_range(20, 80);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Fields that the operation ignores still carry random values.
   task automatic send_get();
      send_request(lpr_pkg::OP_GET, lpr_pkg::LEN_W'($urandom_range(0, lpr_pkg::FREE_SAT)),
                   lpr_pkg::DATA_W'($urandom));
   endtask

   task automatic send_byte(logic [lpr_pkg::DATA_W-1:0] din);
      send_request(lpr_pkg::OP_PUT, lpr_pkg::LEN_W'($urandom_range(0, lpr_pkg::FREE_SAT)),
                   din);
   endtask

   task automatic send_start(int unsigned length);
      send_request(lpr_pkg::OP_START, lpr_pkg::LEN_W'(length), lpr_pkg::DATA_W'($urandom));
   endtask

   // Sender pause until every outstanding response has come back.
   task automatic wait_idle();
      if (tracker.pending() == 0) return;
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   // Packet lengths: mostly short, some medium, a few up to a few hundred.
   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 72) return $urandom_range(1, 12);
      if (r < 95) return $urandom_range(13, 64);
      return $urandom_range(65, 300);
   endfunction

   // A well-formed packet, with the odd stray transaction slipped in.
   task automatic put_packet(int unsigned length);
      send_start(length);
      if (!tracker.put_open()) return;
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(0, 99) < 8) begin
            case ($urandom_range(0, 2))
               0: send_get();
               1: send_request(OP_UNUSED, lpr_pkg::LEN_W'($urandom),
                               lpr_pkg::DATA_W'($urandom));
               default: send_start($urandom_range(1, 64));
            endcase
         end
         send_byte(lpr_pkg::DATA_W'($urandom));
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus.
   // -------------------------------------------------------------------------
   initial begin
      int unsigned random_start;
      hold_left = 0;
      calm_items = 0;
      items_sent = 0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = lpr_pkg::OP_START;
      req_bus.packet_length = '0;
      req_bus.data_in = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: errors and rejects on an empty ring.
      send_get();
      send_byte(8'h3C);
      send_request(OP_UNUSED, '1, '1);
      send_start(0);
      send_start(lpr_pkg::FREE_SAT);
      send_start(MAX_PACKET + 1);

      // Directed: two packets, a start while a put is open, then read back.
      send_start(3);
      send_start(2);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hA5);
      send_start(1);
      send_byte(8'h5A);
      repeat (5) send_get();
      wait_idle();

      // Receiver holds off while the sender keeps offering transactions.
      hold_left = 150;
      put_packet(10);
      repeat (4) send_get();
      wait_idle();

      // Random traffic: mostly packets and reads, with some noise.
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 99)) inside
            [0:54]: put_packet(pick_length());
            [55:84]: repeat ($urandom_range(1, 40)) send_get();
            [85:96]: begin
               case ($urandom_range(0, 3))
                  0: send_request(OP_UNUSED, lpr_pkg::LEN_W'($urandom),
                                  lpr_pkg::DATA_W'($urandom));
                  1: send_byte(lpr_pkg::DATA_W'($urandom));
                  2: send_start(0);
                  default: send_start($urandom_range(MAX_PACKET + 1, lpr_pkg::FREE_SAT));
               endcase
            end
            default: wait_idle();
         endcase
      end

      // Finish any open put so the ring ends in a consistent state.
      while (tracker.put_open()) send_byte(lpr_pkg::DATA_W'($urandom));
      wait_idle();
      repeat (20) @(posedge clock);
      tracker.report_leftover();

      $display("Covered %0d requests: %0d starts, %0d data bytes, %0d gets, %0d undefined.",
               items_sent, tracker.op_seen[lpr_pkg::OP_START],
               tracker.op_seen[lpr_pkg::OP_PUT], tracker.op_seen[lpr_pkg::OP_GET],
               tracker.op_seen[OP_UNUSED]);
      $display("Statuses: ok %0d, empty %0d, rejected %0d, sequence %0d; largest packet %0d.",
               tracker.status_seen[lpr_pkg::ST_OK], tracker.status_seen[lpr_pkg::ST_EMPTY],
               tracker.status_seen[lpr_pkg::ST_FULL], tracker.status_seen[lpr_pkg::ST_SEQ],
               tracker.biggest_packet);
      if (tracker.failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches in total", tracker.failures);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
